@@ rtl/ltfe_pkg.sv @@
// ----------------------------------------------------------------------------
// ltfe_pkg
// Shared widths, codes and types of the LED twinkle fade engine.
// ----------------------------------------------------------------------------
package ltfe_pkg;

  // LED store geometry
  localparam int unsigned NUM_LEDS = 512;
  localparam int unsigned LedAw    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int unsigned LedCw    = $clog2(NUM_LEDS + 1);

  // Field widths
  localparam int unsigned IdxW  = 9;
  localparam int unsigned TimeW = 32;
  localparam int unsigned DrawW = 17;
  localparam int unsigned ColW  = 24;
  localparam int unsigned ChW   = 8;
  localparam int unsigned BrW   = 8;
  localparam int unsigned ThrW  = 17;
  localparam int unsigned PerW  = 32;

  // Stream word widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 48;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_SPAWN_THR   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_RAMP_PERIOD = 1'd1;
  localparam logic [ThrW-1:0]    SPAWN_THR_RST   = '0;
  localparam logic [PerW-1:0]    RAMP_PERIOD_RST = 32'd1000;

  // Queue between front and back
  localparam int unsigned QDepth = 4;

  // Brightness
  localparam logic [BrW-1:0] BRIGHT_FULL = 8'd255;
  localparam logic [BrW-1:0] BRIGHT_MIN  = 8'd3;

  // LED modes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_OFF  = 2'd0;
  localparam mode_t MODE_RISE = 2'd1;
  localparam mode_t MODE_FALL = 2'd2;

  // How the back end forms the brightness of a word
  typedef enum logic [1:0] {
    BK_ZERO,
    BK_FULL,
    BK_DIV
  } br_kind_e;

  // One LED entry of the store
  typedef struct packed {
    mode_t             mode;
    logic [TimeW-1:0]  start;
    logic [ColW-1:0]   color;
  } led_state_t;

  // Classified word passed from front to back
  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic             last;
    logic [ColW-1:0]  color;
    br_kind_e         kind;
    logic [PerW-1:0]  ramp_x;
  } work_t;

  // Configuration seen by front and back
  typedef struct packed {
    logic [ThrW-1:0] spawn_thr;
    logic [PerW-1:0] period;
  } cfg_t;

endpackage

@@ rtl/led_twinkle_fade_engine_core.sv @@
// ----------------------------------------------------------------------------
// led_twinkle_fade_engine_core
// Per-LED twinkle engine: spawns, ramps up and fades each LED and returns
// its colour scaled by the current brightness.
//
//   channel   direction  payload (low bit first)                   last
//   s_axis    in         led_index, now_ms, random_draw, new_color  frame_last
//   m_axis    out        pixel_index, pixel_color, pixel_brightness show_frame
//   cfg       in         0 spawn_threshold, 1 ramp_period_ms        -
//
// One word per clock sustained in and out while the output is not stalled; a
// word passes the mode stage, the queue and the 8-stage ramp divider, then
// the scaling and output registers.
// After reset a clearing pass over all NUM_LEDS (512) entries blanks the LED store;
// s_axis_tready stays low meanwhile, configuration writes are taken.
// An output stall freezes the back pipe; the 4-word queue then fills and
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module led_twinkle_fade_engine_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [ltfe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ltfe_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Update words in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // led_index[8:0], now_ms[40:9], random_draw[57:41], new_color[81:58]
  input  logic [ltfe_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tlast,
  // Pixel words out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pixel_index[8:0], pixel_color[32:9], pixel_brightness[40:33]
  output logic [ltfe_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);
  import ltfe_pkg::*;

  logic [ThrW-1:0] thr_q;
  logic [PerW-1:0] per_q;
  cfg_t            cfg;
  logic            q_push_valid;
  logic            q_push_ready;
  work_t           q_push_item;
  logic            q_pop_valid;
  logic            q_pop_ready;
  work_t           q_pop_item;
  logic [IdxW-1:0] out_idx;
  logic [ColW-1:0] out_color;
  logic [BrW-1:0]  out_bright;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= SPAWN_THR_RST;
      per_q <= RAMP_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPAWN_THR:   thr_q <= cfg_wdata_i[ThrW-1:0];
        CFG_RAMP_PERIOD: per_q <= cfg_wdata_i[PerW-1:0];
        default: ;
      endcase
    end
  end

  // A zero period runs as one millisecond
  assign cfg.spawn_thr = thr_q;
  assign cfg.period    = (per_q == '0) ? PerW'(1) : per_q;

  ltfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_idx_i     (s_axis_tdata[8:0]),
    .in_now_i     (s_axis_tdata[40:9]),
    .in_draw_i    (s_axis_tdata[57:41]),
    .in_color_i   (s_axis_tdata[81:58]),
    .in_last_i    (s_axis_tlast),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_item_o  (q_push_item)
  );

  ltfe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_item_i  (q_push_item),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_item_o   (q_pop_item)
  );

  ltfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .pop_valid_i  (q_pop_valid),
    .pop_ready_o  (q_pop_ready),
    .pop_item_i   (q_pop_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_idx_o    (out_idx),
    .out_color_o  (out_color),
    .out_bright_o (out_bright),
    .out_last_o   (m_axis_tlast)
  );

  // Pack the pixel word
  assign m_axis_tdata = {{(OutDataW - IdxW - ColW - BrW){1'b0}}, out_bright, out_color, out_idx};

endmodule

@@ rtl/ltfe_front.sv @@
// ----------------------------------------------------------------------------
// ltfe_front
// Accepts LED update words, runs the per-LED mode machine against the state
// store and classifies each word for the brightness back end.
// ----------------------------------------------------------------------------
module ltfe_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ltfe_pkg::cfg_t          cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ltfe_pkg::IdxW-1:0]  in_idx_i,
  input  logic [ltfe_pkg::TimeW-1:0] in_now_i,
  input  logic [ltfe_pkg::DrawW-1:0] in_draw_i,
  input  logic [ltfe_pkg::ColW-1:0]  in_color_i,
  input  logic                    in_last_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output ltfe_pkg::work_t         push_item_o
);
  import ltfe_pkg::*;

  // State store and its registered read port
  led_state_t mem_q [NUM_LEDS];
  led_state_t rd_q;

  // Clearing pass after reset
  logic             clr_busy_q;
  logic [LedCw-1:0] clr_cnt_q;

  // Update stage
  logic             s1_vld_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic [TimeW-1:0] s1_now_q;
  logic [DrawW-1:0] s1_draw_q;
  logic [ColW-1:0]  s1_color_q;
  logic             s1_last_q;

  // Last write, forwarded to a following word for the same LED
  logic             wb_vld_q;
  logic [IdxW-1:0]  wb_idx_q;
  led_state_t       wb_st_q;

  logic             accept;
  logic             s1_adv;
  logic             s1_in_range;
  logic             s1_wr;
  led_state_t       cur;
  led_state_t       nxt;
  logic             spawn;
  logic [TimeW-1:0] run;
  br_kind_e         kind;
  logic [PerW-1:0]  ramp_x;
  logic             mem_we;
  logic [LedAw-1:0] mem_waddr;
  led_state_t       mem_wdata;

  // Handshake: hold off while clearing or while the update stage is blocked
  assign s1_adv     = s1_vld_q && push_ready_i;
  assign in_ready_o = !clr_busy_q && (!s1_vld_q || push_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Mode machine for the word in the update stage
  always_comb begin
    s1_in_range = (32'(s1_idx_q) < NUM_LEDS);
    cur   = (wb_vld_q && (wb_idx_q == s1_idx_q)) ? wb_st_q : rd_q;
    spawn = (cur.mode == MODE_OFF) && (s1_draw_q < cfg_i.spawn_thr);
    nxt   = cur;
    if (spawn) begin
      nxt.mode  = MODE_RISE;
      nxt.color = s1_color_q;
      nxt.start = s1_now_q;
    end
    run    = spawn ? '0 : (s1_now_q - cur.start);
    kind   = BK_ZERO;
    ramp_x = '0;
    unique case (nxt.mode)
      MODE_RISE: begin
        if (run >= cfg_i.period) begin
          kind = BK_FULL;
          if (run > cfg_i.period) begin
            nxt.mode  = MODE_FALL;
            nxt.start = s1_now_q;
          end
        end else begin
          kind   = BK_DIV;
          ramp_x = run;
        end
      end
      MODE_FALL: begin
        if (run > cfg_i.period) begin
          nxt.mode = MODE_OFF;
        end else begin
          kind   = BK_DIV;
          ramp_x = cfg_i.period - run;
        end
      end
      default: ;
    endcase
    // An LED beyond the store shows black and keeps no state
    if (!s1_in_range) begin
      kind = BK_ZERO;
    end
  end

  assign s1_wr = s1_adv && s1_in_range;

  // Store write: clearing pass first, then updates
  assign mem_we    = clr_busy_q || s1_wr;
  assign mem_waddr = clr_busy_q ? clr_cnt_q[LedAw-1:0] : LedAw'(s1_idx_q);
  assign mem_wdata = clr_busy_q ? '0 : nxt;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_q <= mem_q[LedAw'(in_idx_i)];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      s1_vld_q   <= 1'b0;
      wb_vld_q   <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        if (clr_cnt_q == LedCw'(NUM_LEDS - 1)) begin
          clr_busy_q <= 1'b0;
        end
        clr_cnt_q <= clr_cnt_q + LedCw'(1);
      end
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_wr) begin
        wb_vld_q <= 1'b1;
      end
    end
  end

  // Payload of the update stage and the forwarding register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q   <= in_idx_i;
      s1_now_q   <= in_now_i;
      s1_draw_q  <= in_draw_i;
      s1_color_q <= in_color_i;
      s1_last_q  <= in_last_i;
    end
    if (s1_wr) begin
      wb_idx_q <= s1_idx_q;
      wb_st_q  <= nxt;
    end
  end

  // Classified word towards the queue
  assign push_valid_o       = s1_vld_q;
  assign push_item_o.idx    = s1_idx_q;
  assign push_item_o.last   = s1_last_q;
  assign push_item_o.color  = nxt.color;
  assign push_item_o.kind   = kind;
  assign push_item_o.ramp_x = ramp_x;

endmodule

@@ rtl/ltfe_queue.sv @@
// ----------------------------------------------------------------------------
// ltfe_queue
// Short word queue that decouples the mode machine from the back end.
// ----------------------------------------------------------------------------
module ltfe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ltfe_pkg::work_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output ltfe_pkg::work_t pop_item_o
);
  import ltfe_pkg::*;

  localparam int unsigned QAw = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCw = $clog2(QDepth + 1);

  work_t          slot_q [QDepth];
  logic [QAw-1:0] wr_ptr_q;
  logic [QAw-1:0] rd_ptr_q;
  logic [QCw-1:0] cnt_q;
  logic           push;
  logic           pop;

  assign push_ready_o = (cnt_q != QCw'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = slot_q[rd_ptr_q];

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QAw'(QDepth - 1)) ? '0 : wr_ptr_q + QAw'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QAw'(QDepth - 1)) ? '0 : rd_ptr_q + QAw'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCw'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCw'(1);
      end
    end
  end

endmodule

@@ rtl/ltfe_back.sv @@
// ----------------------------------------------------------------------------
// ltfe_back
// Brightness back end: pipelined ramp divider, one quotient bit a stage,
// then channel scaling and the output register.
// ----------------------------------------------------------------------------
module ltfe_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ltfe_pkg::cfg_t            cfg_i,
  input  logic                      pop_valid_i,
  output logic                      pop_ready_o,
  input  ltfe_pkg::work_t           pop_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ltfe_pkg::IdxW-1:0] out_idx_o,
  output logic [ltfe_pkg::ColW-1:0] out_color_o,
  output logic [ltfe_pkg::BrW-1:0]  out_bright_o,
  output logic                      out_last_o
);
  import ltfe_pkg::*;

  localparam int unsigned DivSteps = BrW;
  localparam int unsigned RemW     = PerW + BrW;
  localparam int unsigned NumCh    = ColW / ChW;
  localparam int unsigned ProdW    = ChW + BrW;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [BrW-1:0]  quo;
    br_kind_e        kind;
    logic [ColW-1:0] color;
    logic [IdxW-1:0] idx;
    logic            last;
  } div_t;

  // floor(p / 255) for a product of two 8-bit values
  function automatic logic [ChW-1:0] div255(input logic [ProdW-1:0] p);
    logic [ProdW:0] t;
    t = (ProdW+1)'(p) + (ProdW+1)'(p >> BrW) + (ProdW+1)'(1);
    return t[ProdW-1:BrW];
  endfunction

  logic                          adv;
  logic [DivSteps:0]             dv_vld_q;
  div_t                          dv_q [DivSteps+1];
  div_t                          dv_d [DivSteps];
  logic [RemW-1:0]               den_ext;
  div_t                          load;
  logic [BrW-1:0]                bright;
  logic [NumCh-1:0][ProdW-1:0]   prod;

  logic                          mu_vld_q;
  logic [NumCh-1:0][ProdW-1:0]   mu_prod_q;
  logic [BrW-1:0]                mu_br_q;
  logic [IdxW-1:0]               mu_idx_q;
  logic                          mu_last_q;

  logic                          out_vld_q;
  logic [ColW-1:0]               out_color_q;
  logic [BrW-1:0]                out_br_q;
  logic [IdxW-1:0]               out_idx_q;
  logic                          out_last_q;

  // The whole pipe moves unless a finished word waits at the output
  assign adv         = !out_vld_q || out_ready_i;
  assign pop_ready_o = adv;
  assign den_ext     = {{BrW{1'b0}}, cfg_i.period};

  // Load: numerator 255 * x
  always_comb begin
    load.rem   = {pop_item_i.ramp_x, {BrW{1'b0}}} - {{BrW{1'b0}}, pop_item_i.ramp_x};
    load.quo   = '0;
    load.kind  = pop_item_i.kind;
    load.color = pop_item_i.color;
    load.idx   = pop_item_i.idx;
    load.last  = pop_item_i.last;
  end

  // Restoring division: one quotient bit per stage, MSB first
  always_comb begin
    for (int s = 0; s < DivSteps; s++) begin
      dv_d[s] = dv_q[s];
      if (dv_q[s].rem >= (den_ext << (DivSteps - 1 - s))) begin
        dv_d[s].rem = dv_q[s].rem - (den_ext << (DivSteps - 1 - s));
        dv_d[s].quo[DivSteps - 1 - s] = 1'b1;
      end
    end
  end

  // Pick the brightness, drop the dimmest levels, scale the channels
  always_comb begin
    unique case (dv_q[DivSteps].kind)
      BK_DIV:  bright = dv_q[DivSteps].quo;
      BK_FULL: bright = BRIGHT_FULL;
      default: bright = '0;
    endcase
    if (bright < BRIGHT_MIN) begin
      bright = '0;
    end
    for (int c = 0; c < NumCh; c++) begin
      prod[c] = ProdW'(dv_q[DivSteps].color[c*ChW +: ChW]) * ProdW'(bright);
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q  <= '0;
      mu_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      dv_vld_q  <= {dv_vld_q[DivSteps-1:0], pop_valid_i};
      mu_vld_q  <= dv_vld_q[DivSteps];
      out_vld_q <= mu_vld_q;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= load;
      for (int s = 0; s < DivSteps; s++) begin
        dv_q[s+1] <= dv_d[s];
      end
      mu_prod_q <= prod;
      mu_br_q   <= bright;
      mu_idx_q  <= dv_q[DivSteps].idx;
      mu_last_q <= dv_q[DivSteps].last;
      for (int c = 0; c < NumCh; c++) begin
        out_color_q[c*ChW +: ChW] <= div255(mu_prod_q[c]);
      end
      out_br_q   <= mu_br_q;
      out_idx_q  <= mu_idx_q;
      out_last_q <= mu_last_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_idx_o    = out_idx_q;
  assign out_color_o  = out_color_q;
  assign out_bright_o = out_br_q;
  assign out_last_o   = out_last_q;

endmodule

@@ rtl/ltfe_checker.sv @@
// ----------------------------------------------------------------------------
// ltfe_checker
// Port-level checks of the twinkle engine, bound to the top level.
// ----------------------------------------------------------------------------
module ltfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // No input taken and no pixel shown in the first cycle after reset
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> (!s_axis_tready && !m_axis_tvalid))
    else $error("ltfe: activity right after reset");

  // A stalled pixel word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("ltfe: pixel word changed under stall");

  // Scaled channels never exceed the brightness
  a_scale_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[32:25] <= m_axis_tdata[40:33]) &&
                       (m_axis_tdata[24:17] <= m_axis_tdata[40:33]) &&
                       (m_axis_tdata[16:9]  <= m_axis_tdata[40:33])))
    else $error("ltfe: channel brighter than brightness");

  // The dimmest levels are blanked
  a_dim_cut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[40:33] == 8'd0) || (m_axis_tdata[40:33] >= 8'd3)))
    else $error("ltfe: brightness below cut-off");

endmodule

bind led_twinkle_fade_engine_core ltfe_checker u_ltfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
